// File: src/tcr_pkg.sv
// Shared types and constants for the tile clip region block.
// No dependencies.
package tcr_pkg;

  localparam int ZOOM_FRAC_BITS_DEF = 8;
  localparam int ZOOM_W = 16;
  localparam int TILE_W = 15;
  localparam int DIV_W = 33;   // dividend and quotient width, fits any fraction width 4..16
  localparam int POS_W = 34;   // signed mural position width
  localparam int OUT_W = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_X      = 2'd0,
    REG_TILE_Y      = 2'd1,
    REG_TILE_WIDTH  = 2'd2,
    REG_TILE_HEIGHT = 2'd3
  } cfg_reg_t;

  // Per-axis data that rides alongside the dividers.
  typedef struct packed {
    logic        outside;
    logic [14:0] i0;     // source start
    logic [15:0] i1;     // source end
    logic [16:0] d;      // signed tile destination
  } axis_side_t;

endpackage

// File: src/tcr_front.sv
// Front stages: zoomed extent multiply, then edge tests and trim dividends.
// Depends on tcr_pkg.
module tcr_front #(
  parameter int ZOOM_FRAC_BITS = tcr_pkg::ZOOM_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [15:0]                   dest_x,
  input  logic signed [15:0]                   dest_y,
  input  logic [14:0]                          src_x,
  input  logic [14:0]                          src_y,
  input  logic [14:0]                          src_width,
  input  logic [14:0]                          src_height,
  input  logic [15:0]                          zoom_factor,
  input  logic [14:0]                          tile_x,
  input  logic [14:0]                          tile_y,
  input  logic [14:0]                          tile_width,
  input  logic [14:0]                          tile_height,
  output logic                                 out_vld,
  output logic [tcr_pkg::ZOOM_W-1:0]           zoom,
  output logic [3:0][tcr_pkg::DIV_W-1:0]       dividend,
  output tcr_pkg::axis_side_t                  side_x,
  output tcr_pkg::axis_side_t                  side_y
);
  import tcr_pkg::*;

  // stage 1
  logic               v1;
  logic signed [15:0] dx1, dy1;
  logic [14:0]        sx1, sy1, sw1, sh1;
  logic [15:0]        zm1;
  logic [30:0]        ext_x1, ext_y1;
  logic [15:0]        zm_fix;
  logic [30:0]        prod_x, prod_y;

  assign zm_fix = (zoom_factor == '0) ? 16'd1 : zoom_factor;
  assign prod_x = 31'(src_width * zm_fix);
  assign prod_y = 31'(src_height * zm_fix);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      dx1    <= dest_x;
      dy1    <= dest_y;
      sx1    <= src_x;
      sy1    <= src_y;
      sw1    <= src_width;
      sh1    <= src_height;
      zm1    <= zm_fix;
      ext_x1 <= prod_x >> ZOOM_FRAC_BITS;
      ext_y1 <= prod_y >> ZOOM_FRAC_BITS;
    end
  end

  // stage 2: axis tests
  function automatic void axis_eval(
    input  logic signed [15:0] dst,
    input  logic [14:0]        src,
    input  logic [14:0]        size,
    input  logic [30:0]        ext,
    input  logic [14:0]        vo,
    input  logic [14:0]        vs,
    output axis_side_t         sd,
    output logic [DIV_W-1:0]   dv_far,
    output logic [DIV_W-1:0]   dv_near
  );
    logic signed [POS_W-1:0] p0, p1, vo_s, vend, dfar, dnear;
    logic                    far_c, near_c;
    p0     = POS_W'(dst);
    p1     = p0 + $signed({3'b0, ext});
    vo_s   = $signed({19'b0, vo});
    vend   = vo_s + $signed({19'b0, vs});
    dfar   = p1 - vend;
    dnear  = vo_s - p0;
    far_c  = p1 > vend;
    near_c = p0 < vo_s;
    sd.outside = (p1 < vo_s) || (p0 > vend);
    sd.i0 = src;
    sd.i1 = {1'b0, src} + {1'b0, size};
    dv_far  = '0;
    dv_near = '0;
    if (sd.outside) begin
      sd.d = 17'(dst);
    end else begin
      if (far_c) dv_far = DIV_W'(dfar << ZOOM_FRAC_BITS);
      if (near_c) begin
        dv_near = DIV_W'(dnear << ZOOM_FRAC_BITS);
        sd.d = '0;
      end else begin
        sd.d = 17'(p0 - vo_s);
      end
    end
  endfunction

  axis_side_t       sx_c, sy_c;
  logic [DIV_W-1:0] fx, nx, fy, ny;

  always_comb begin
    axis_eval(dx1, sx1, sw1, ext_x1, tile_x, tile_width, sx_c, fx, nx);
    axis_eval(dy1, sy1, sh1, ext_y1, tile_y, tile_height, sy_c, fy, ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v1;
    end
    if (en) begin
      zoom     <= zm1;
      dividend <= {ny, fy, nx, fx};
      side_x   <= sx_c;
      side_y   <= sy_c;
    end
  end

endmodule

// File: src/tcr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing
// one divisor, with a sideband that travels alongside. Depends on tcr_pkg.
module tcr_div_pipe #(
  parameter int SB_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [tcr_pkg::ZOOM_W-1:0]           divisor,
  input  logic [3:0][tcr_pkg::DIV_W-1:0]       dividend,
  input  logic [SB_W-1:0]                      sb_in,
  output logic                                 out_vld,
  output logic [3:0][tcr_pkg::DIV_W-1:0]       quotient,
  output logic [SB_W-1:0]                      sb_out
);
  import tcr_pkg::*;

  localparam int NSTG = DIV_W;

  logic                         v   [NSTG];
  logic [ZOOM_W-1:0]            zm  [NSTG];
  logic [3:0][DIV_W-1:0]        num [NSTG];
  logic [3:0][DIV_W-1:0]        quo [NSTG];
  logic [3:0][ZOOM_W-1:0]       rem [NSTG];
  logic [SB_W-1:0]              sb  [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    logic                   pv;
    logic [ZOOM_W-1:0]      pz;
    logic [3:0][DIV_W-1:0]  pn, pq, nn, nq;
    logic [3:0][ZOOM_W-1:0] pr, nr;
    logic [SB_W-1:0]        ps;

    if (j == 0) begin : g_first
      assign pv = in_vld;
      assign pz = divisor;
      assign pn = dividend;
      assign pq = '0;
      assign pr = '0;
      assign ps = sb_in;
    end else begin : g_next
      assign pv = v[j-1];
      assign pz = zm[j-1];
      assign pn = num[j-1];
      assign pq = quo[j-1];
      assign pr = rem[j-1];
      assign ps = sb[j-1];
    end

    always_comb begin
      logic [ZOOM_W:0] t;
      for (int l = 0; l < 4; l++) begin
        t = {pr[l], pn[l][DIV_W-1]};
        nn[l] = pn[l] << 1;
        if (t >= {1'b0, pz}) begin
          nr[l] = ZOOM_W'(t - {1'b0, pz});
          nq[l] = {pq[l][DIV_W-2:0], 1'b1};
        end else begin
          nr[l] = t[ZOOM_W-1:0];
          nq[l] = {pq[l][DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= pv;
      end
      if (en) begin
        zm[j]  <= pz;
        num[j] <= nn;
        quo[j] <= nq;
        rem[j] <= nr;
        sb[j]  <= ps;
      end
    end
  end

  assign out_vld  = v[NSTG-1];
  assign quotient = quo[NSTG-1];
  assign sb_out   = sb[NSTG-1];

endmodule

// File: src/tile_clip_region.sv
// Top level of the tile clip region block: config registers, front stages,
// divider pipeline and output register. Depends on tcr_pkg, tcr_front,
// tcr_div_pipe.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+------------------------
//  in      | dest_x/y, src_x/y, src_width/height, | in_valid, in_stall
//          | zoom_factor                          |
//  out     | clip_x/y, clip_width/height,         | out_valid, out_stall
//          | tile_dest_x/y                        |
//  cfg     | cfg_index, cfg_data                  | cfg_valid, cfg_ready
//
// One word enters per cycle unless the output stalls. The pipeline holds two front stages
// (multiply, edge tests), 33 divider stages (one quotient bit each), and the
// output register; its depth is set by the one-bit-per-stage divider chain.
// Synchronous reset clears all valid bits and the tile registers to zero.
// A stall on a valid output word freezes the whole pipeline; in_stall follows it, so
// bubbles are held rather than squeezed out. cfg_ready is always high.
module tile_clip_region #(
  parameter int ZOOM_FRAC_BITS = tcr_pkg::ZOOM_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [14:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              dest_x,
  input  logic signed [15:0]              dest_y,
  input  logic [14:0]                     src_x,
  input  logic [14:0]                     src_y,
  input  logic [14:0]                     src_width,
  input  logic [14:0]                     src_height,
  input  logic [15:0]                     zoom_factor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              clip_x,
  output logic signed [31:0]              clip_y,
  output logic signed [31:0]              clip_width,
  output logic signed [31:0]              clip_height,
  output logic signed [31:0]              tile_dest_x,
  output logic signed [31:0]              tile_dest_y
);
  import tcr_pkg::*;

  localparam int SB_W = 2 * $bits(axis_side_t);

  logic [14:0] tile_x, tile_y, tile_width, tile_height;
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_x      <= '0;
      tile_y      <= '0;
      tile_width  <= '0;
      tile_height <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TILE_X:      tile_x      <= cfg_data;
        REG_TILE_Y:      tile_y      <= cfg_data;
        REG_TILE_WIDTH:  tile_width  <= cfg_data;
        REG_TILE_HEIGHT: tile_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Everything moves together unless a finished word is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic                  f_vld;
  logic [ZOOM_W-1:0]     f_zoom;
  logic [3:0][DIV_W-1:0] f_div;
  axis_side_t            f_sx, f_sy;

  tcr_front #(.ZOOM_FRAC_BITS(ZOOM_FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_vld(in_valid),
    .dest_x, .dest_y, .src_x, .src_y, .src_width, .src_height, .zoom_factor,
    .tile_x, .tile_y, .tile_width, .tile_height,
    .out_vld(f_vld), .zoom(f_zoom), .dividend(f_div),
    .side_x(f_sx), .side_y(f_sy)
  );

  logic                  d_vld;
  logic [3:0][DIV_W-1:0] q;
  logic [SB_W-1:0]       d_sb;
  axis_side_t            ax, ay;

  tcr_div_pipe #(.SB_W(SB_W)) u_div (
    .clk, .rst, .en,
    .in_vld(f_vld), .divisor(f_zoom), .dividend(f_div),
    .sb_in({f_sy, f_sx}),
    .out_vld(d_vld), .quotient(q), .sb_out(d_sb)
  );

  assign {ay, ax} = d_sb;

  // Lane order: 0 far x, 1 near x, 2 far y, 3 near y. Unused trims are zero.
  logic [OUT_W-1:0] cx, cw, cy, ch;
  logic [OUT_W-1:0] x0, x1, y0, y1;

  always_comb begin
    x0 = OUT_W'(ax.i0) + OUT_W'(q[1]);
    x1 = OUT_W'(ax.i1) - OUT_W'(q[0]);
    y0 = OUT_W'(ay.i0) + OUT_W'(q[3]);
    y1 = OUT_W'(ay.i1) - OUT_W'(q[2]);
    cx = ax.outside ? '0 : x0;
    cw = ax.outside ? '0 : x1 - x0;
    cy = ay.outside ? '0 : y0;
    ch = ay.outside ? '0 : y1 - y0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
    if (en) begin
      clip_x      <= cx;
      clip_y      <= cy;
      clip_width  <= cw;
      clip_height <= ch;
      tile_dest_x <= OUT_W'($signed(ax.d));
      tile_dest_y <= OUT_W'($signed(ay.d));
    end
  end

endmodule
